### hdl/pmsw_pkg.sv
// pmsw_pkg: shared event codes, register indexes and result word type
// for the pump and motion safety watchdog; no dependencies
package pmsw_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STAMP_IN_W = 32;
  localparam int unsigned TIMEOUT_W = 32;

  // event codes
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_VELOCITY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PUMP = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LINK = 2'd3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PUMP_TIMEOUT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MOTION_TIMEOUT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PUMP_ACTIVE_HIGH = 2'd2;

  localparam logic [TIMEOUT_W-1:0] MOTION_TIMEOUT_RESET = 32'd1000;

  typedef struct packed {
    logic pump_timed_out;
    logic stop_motion;
    logic pump_on;
    logic pump_pin;
  } result_t;

endpackage

### hdl/pump_motion_safety_watchdog.sv
// pump_motion_safety_watchdog: top level with input and result registers,
// watchdog state and configuration registers; depends on pmsw_pkg, pmsw_core
//
// Usage:
//   s_axis carries one event word: tuser holds the event code, tdata the
//   timestamp and the request and link flags. m_axis returns one result word
//   per event, in order. cfg_* writes a register by index at any time the
//   block is idle; cfg_ready_o is always high, and index 3 is ignored.
// Flow: a word accepted into the input register is evaluated against the
//   watchdog state and moves into the result register once that register is
//   free or being read; the result is then offered on m_axis.
// Throughput: one event per cycle while m_axis_tready is high; the state
//   update is a single subtract and compare per timer between the registers.
// Reset: link down, pump off, both stamps zero, pump timeout 0 (off), motion
//   timeout 1000 ms, pump active high; both registers empty.
// Stall: while m_axis_tready is low the result holds, one more word may sit
//   in the input register, and s_axis_tready drops once both are full.
module pump_motion_safety_watchdog import pmsw_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] now_ms, [32] pump_request, [33] link_up, [39:34] zero
  input  logic [39:0]           s_axis_tdata,
  // [1:0] func
  input  logic [FUNC_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] pump_pin, [1] pump_on, [2] stop_motion, [3] pump_timed_out, [7:4] zero
  output logic [7:0]            m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned EXT_W = (TIME_WIDTH > STAMP_IN_W) ? TIME_WIDTH : STAMP_IN_W;

  logic                  in_valid_q;
  logic [FUNC_W-1:0]     func_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic                  req_q;
  logic                  link_q;
  logic                  out_valid_q;
  result_t               result_q;

  logic [TIMEOUT_W-1:0]  pump_timeout_q;
  logic [TIMEOUT_W-1:0]  motion_timeout_q;
  logic                  active_high_q;
  logic                  connected_q;
  logic                  pump_enabled_q;
  logic [TIME_WIDTH-1:0] pump_stamp_q;
  logic [TIME_WIDTH-1:0] velocity_stamp_q;

  logic                  connected_d;
  logic                  pump_enabled_d;
  logic [TIME_WIDTH-1:0] pump_stamp_d;
  logic [TIME_WIDTH-1:0] velocity_stamp_d;
  result_t               result_d;

  logic                  advance;
  logic                  in_take;
  logic [EXT_W-1:0]      now_ext;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign now_ext       = EXT_W'(s_axis_tdata[STAMP_IN_W-1:0]);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, result_q};

  pmsw_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .func_i            (func_q),
    .now_i             (now_q),
    .pump_request_i    (req_q),
    .link_up_i         (link_q),
    .pump_timeout_i    (pump_timeout_q),
    .motion_timeout_i  (motion_timeout_q),
    .pump_active_high_i(active_high_q),
    .connected_i       (connected_q),
    .pump_enabled_i    (pump_enabled_q),
    .pump_stamp_i      (pump_stamp_q),
    .velocity_stamp_i  (velocity_stamp_q),
    .connected_o       (connected_d),
    .pump_enabled_o    (pump_enabled_d),
    .pump_stamp_o      (pump_stamp_d),
    .velocity_stamp_o  (velocity_stamp_d),
    .result_o          (result_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= s_axis_tuser;
      now_q  <= now_ext[TIME_WIDTH-1:0];
      req_q  <= s_axis_tdata[32];
      link_q <= s_axis_tdata[33];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      result_q    <= result_d;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // watchdog state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connected_q      <= 1'b0;
      pump_enabled_q   <= 1'b0;
      pump_stamp_q     <= '0;
      velocity_stamp_q <= '0;
    end else if (advance) begin
      connected_q      <= connected_d;
      pump_enabled_q   <= pump_enabled_d;
      pump_stamp_q     <= pump_stamp_d;
      velocity_stamp_q <= velocity_stamp_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_timeout_q   <= '0;
      motion_timeout_q <= MOTION_TIMEOUT_RESET;
      active_high_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_PUMP_TIMEOUT:     pump_timeout_q   <= cfg_data_i[TIMEOUT_W-1:0];
        REG_MOTION_TIMEOUT:   motion_timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
        REG_PUMP_ACTIVE_HIGH: active_high_q    <= cfg_data_i[0];
        default: begin
          active_high_q <= active_high_q;
        end
      endcase
    end
  end

endmodule

### hdl/pmsw_core.sv
// pmsw_core: next-state and result logic for one event of the watchdog
// depends on pmsw_pkg
module pmsw_core import pmsw_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic                  pump_request_i,
  input  logic                  link_up_i,
  input  logic [TIMEOUT_W-1:0]  pump_timeout_i,
  input  logic [TIMEOUT_W-1:0]  motion_timeout_i,
  input  logic                  pump_active_high_i,
  input  logic                  connected_i,
  input  logic                  pump_enabled_i,
  input  logic [TIME_WIDTH-1:0] pump_stamp_i,
  input  logic [TIME_WIDTH-1:0] velocity_stamp_i,
  output logic                  connected_o,
  output logic                  pump_enabled_o,
  output logic [TIME_WIDTH-1:0] pump_stamp_o,
  output logic [TIME_WIDTH-1:0] velocity_stamp_o,
  output result_t               result_o
);

  localparam int unsigned CMP_W = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;

  logic [TIME_WIDTH-1:0] pump_elapsed;
  logic [TIME_WIDTH-1:0] vel_elapsed;
  logic                  pump_expired;
  logic                  vel_expired;
  logic                  stop;
  logic                  timed_out;

  // differences wrap at the time width
  assign pump_elapsed = now_i - pump_stamp_i;
  assign vel_elapsed  = now_i - velocity_stamp_i;

  assign pump_expired = pump_enabled_i && (pump_timeout_i != '0) &&
                        (CMP_W'(pump_elapsed) > CMP_W'(pump_timeout_i));
  assign vel_expired  = CMP_W'(vel_elapsed) > CMP_W'(motion_timeout_i);

  always_comb begin
    connected_o      = connected_i;
    pump_enabled_o   = pump_enabled_i;
    pump_stamp_o     = pump_stamp_i;
    velocity_stamp_o = velocity_stamp_i;
    stop             = 1'b0;
    timed_out        = 1'b0;
    case (func_i)
      FUNC_TICK: begin
        if (!connected_i) begin
          stop           = 1'b1;
          pump_enabled_o = 1'b0;
          pump_stamp_o   = now_i;
        end else begin
          if (pump_expired) begin
            pump_enabled_o = 1'b0;
            pump_stamp_o   = now_i;
            timed_out      = 1'b1;
          end
          stop = vel_expired;
        end
      end
      FUNC_VELOCITY: begin
        velocity_stamp_o = now_i;
      end
      FUNC_PUMP: begin
        pump_stamp_o   = now_i;
        pump_enabled_o = pump_request_i && connected_i;
      end
      FUNC_LINK: begin
        connected_o = link_up_i;
        if (link_up_i) begin
          velocity_stamp_o = now_i;
        end else begin
          stop           = 1'b1;
          pump_enabled_o = 1'b0;
          pump_stamp_o   = now_i;
        end
      end
      default: begin
        stop = 1'b0;
      end
    endcase
  end

  always_comb begin
    result_o.pump_pin       = (pump_enabled_o == pump_active_high_i);
    result_o.pump_on        = pump_enabled_o;
    result_o.stop_motion    = stop;
    result_o.pump_timed_out = timed_out;
  end

endmodule
